[rtl/core/ahc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahc_pkg
// Shared types and constants for the actuator homing controller.
// ----------------------------------------------------------------------------
package ahc_pkg;

   // One encoder detent is four quadrature steps in one direction
   localparam int DETENT_STEPS = 4;

   // Length divide by 17: q = (m * DIV_RECIP) >> DIV_SHIFT.
   // DIV_RECIP = ceil(2^20 / 17); the error stays below one for any 16-bit m.
   localparam int          DIV_SHIFT = 20;
   localparam logic [15:0] DIV_RECIP = 16'd61681;
   localparam int          QUOT_W    = 12;

   // Configuration register indexes
   localparam logic [1:0] CSR_MOVE_WINDOW = 2'd0;
   localparam logic [1:0] CSR_SETTLE      = 2'd1;
   localparam logic [1:0] CSR_EXT_LENGTH  = 2'd2;

   // Configuration reset values
   localparam logic [15:0] MOVE_WINDOW_RST = 16'd500;
   localparam logic [15:0] SETTLE_RST      = 16'd5000;
   localparam logic [9:0]  EXT_LENGTH_RST  = 10'd321;

   // One input word as held in the input register
   typedef struct packed {
      logic               enc_a;
      logic               enc_b;
      logic               upper_released;
      logic               lower_released;
      logic               ms_tick;
      logic               cmd_valid;
      logic               speed_present;
      logic signed [15:0] cmd_speed;
   } ahc_sample_type;

   // Configuration register contents
   typedef struct packed {
      logic [15:0] window_ms;
      logic [15:0] settle_ms;
      logic [9:0]  ext_len_mm;
   } ahc_cfg_type;

   // Tracker stage result, handed to the output stage
   typedef struct packed {
      logic signed [15:0] count;
      logic               upper_state;
      logic               moving;
      logic               homed;
      logic signed [15:0] homed_count;
      logic               fwd;
      logic               rev;
      logic [15:0]        diff_mag;
      logic               diff_neg;
   } ahc_track_type;

   // Quadrature transition table, indexed by {previous A,B, current A,B}
   function automatic logic signed [1:0] quad_delta(input logic [3:0] hist);
      logic signed [1:0] d;
      case (hist)
         4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

[rtl/core/ahc_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahc_track
// Encoder decode, speed gating, movement window and homing check. Holds all
// controller state and advances it by one sample per take.
// ----------------------------------------------------------------------------
module ahc_track (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  ahc_pkg::ahc_sample_type smp,
   input  ahc_pkg::ahc_cfg_type    cfg,
   output ahc_pkg::ahc_track_type  trk
);
   import ahc_pkg::*;

   logic [3:0]         hist_ff, hist_in;
   logic signed [3:0]  acc_ff, acc_in;
   logic [15:0]        count_ff, count_in;
   logic signed [15:0] held_ff, held_in;
   logic [15:0]        win_el_ff, win_el_in;
   logic [15:0]        win_cnt_ff, win_cnt_in;
   logic               moving_ff, moving_in;
   logic               chk_ff, chk_in;
   logic [15:0]        settle_ff, settle_in;
   logic               homed_ff, homed_in;
   logic [15:0]        hpos_ff, hpos_in;
   ahc_track_type      trk_ff, trk_in;

   logic signed [3:0]  acc_sum;
   logic signed [15:0] held_cmd;
   logic               pos_cmd, neg_cmd, pos_fin, neg_fin;
   logic [15:0]        win_tick, settle_tick;
   logic signed [16:0] diff;

   always_comb begin
      // quadrature decode and detent count
      hist_in  = {hist_ff[1:0], smp.enc_a, smp.enc_b};
      acc_sum  = acc_ff + 4'(quad_delta(hist_in));
      acc_in   = acc_sum;
      count_in = count_ff;
      if (acc_sum >= 4'(DETENT_STEPS)) begin
         count_in = count_ff + 16'd1;
         acc_in   = '0;
      end else if (acc_sum <= -4'(DETENT_STEPS)) begin
         count_in = count_ff - 16'd1;
         acc_in   = '0;
      end

      // command capture, then limit switch gating
      held_cmd = (smp.cmd_valid && smp.speed_present) ? smp.cmd_speed : held_ff;
      pos_cmd  = !held_cmd[15] && (held_cmd != '0);
      neg_cmd  = held_cmd[15];
      held_in  = held_cmd;
      if ((pos_cmd && !smp.upper_released) || (neg_cmd && !smp.lower_released)) begin
         held_in = '0;
      end
      pos_fin = !held_in[15] && (held_in != '0);
      neg_fin = held_in[15];

      // movement window, saturating ms counter
      win_tick   = (smp.ms_tick && win_el_ff != 16'hFFFF) ? win_el_ff + 16'd1 : win_el_ff;
      win_el_in  = win_tick;
      win_cnt_in = win_cnt_ff;
      moving_in  = moving_ff;
      if (win_tick >= cfg.window_ms) begin
         moving_in  = (count_in != win_cnt_ff);
         win_cnt_in = count_in;
         win_el_in  = '0;
      end

      // homing check: settle timer runs only while a check is open
      settle_tick = (chk_ff && smp.ms_tick && settle_ff != 16'hFFFF) ?
                    settle_ff + 16'd1 : settle_ff;
      settle_in = settle_tick;
      chk_in    = chk_ff;
      homed_in  = homed_ff;
      hpos_in   = hpos_ff;
      if (pos_fin && !chk_ff && smp.cmd_valid) begin
         chk_in    = 1'b1;
         settle_in = '0;
      end
      if (chk_in && settle_in >= cfg.settle_ms) begin
         if (!moving_in && smp.cmd_valid && held_in == 16'sd1) begin
            homed_in = 1'b1;
            hpos_in  = count_in;
         end
         chk_in = 1'b0;
      end

      // result word; length difference split into sign and magnitude
      diff = {hpos_in[15], hpos_in} - {count_in[15], count_in};
      trk_in.count       = count_in;
      trk_in.upper_state = smp.upper_released;
      trk_in.moving      = moving_in;
      trk_in.homed       = homed_in;
      trk_in.homed_count = hpos_in;
      trk_in.fwd         = pos_fin;
      trk_in.rev         = neg_fin;
      trk_in.diff_neg    = diff[16];
      trk_in.diff_mag    = diff[16] ? 16'(-diff) : diff[15:0];
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= 4'd3;
         acc_ff     <= '0;
         count_ff   <= '0;
         held_ff    <= '0;
         win_el_ff  <= '0;
         win_cnt_ff <= '0;
         moving_ff  <= 1'b0;
         chk_ff     <= 1'b0;
         settle_ff  <= '0;
         homed_ff   <= 1'b0;
         hpos_ff    <= '0;
      end else if (take) begin
         hist_ff    <= hist_in;
         acc_ff     <= acc_in;
         count_ff   <= count_in;
         held_ff    <= held_in;
         win_el_ff  <= win_el_in;
         win_cnt_ff <= win_cnt_in;
         moving_ff  <= moving_in;
         chk_ff     <= chk_in;
         settle_ff  <= settle_in;
         homed_ff   <= homed_in;
         hpos_ff    <= hpos_in;
      end
   end

   // stage result register
   always_ff @(posedge clock) begin
      if (take) begin
         trk_ff <= trk_in;
      end
   end

   assign trk = trk_ff;

endmodule

[rtl/core/actuator_homing_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_homing_controller_top
// Quadrature encoder actuator homing controller: sample register, tracker
// stage, length and output stage, plus the configuration registers.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word per input word, in
// order. A word passes three register stages: the sample register, the
// tracker stage (encoder decode, speed gating, movement window and homing
// check, all state updated at once on each take) and the output stage, where the
// homed length is formed with one 16x16 reciprocal multiply for the divide by
// 17. A word goes from the sample register to the tracker stage and then to
// the output stage, where rsp_valid rises; throughput is one word per cycle
// while rsp_stall stays low. Configuration writes are always taken
// (csr_ready is tied high) and should be made while no word is in flight.
// ----------------------------------------------------------------------------
module actuator_homing_controller_top (
   input  logic               clock,
   input  logic               reset,
   // sample channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_enc_a,
   input  logic               req_enc_b,
   input  logic               req_upper_released,
   input  logic               req_lower_released,
   input  logic               req_ms_tick,
   input  logic               req_cmd_valid,
   input  logic               req_speed_present,
   input  logic signed [15:0] req_cmd_speed,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_position_count,
   output logic               rsp_upper_state,
   output logic               rsp_moving,
   output logic               rsp_homed,
   output logic signed [15:0] rsp_homed_count,
   output logic signed [13:0] rsp_length_mm,
   output logic               rsp_drive_forward,
   output logic               rsp_drive_reverse,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import ahc_pkg::*;

   ahc_cfg_type        cfg_ff;
   ahc_sample_type     smp_ff, smp_in;
   logic               smp_vld_ff;
   logic               trk_vld_ff;
   ahc_track_type      trk;
   logic               out_vld_ff;
   ahc_track_type      out_ff;
   logic signed [13:0] len_ff, len_in;

   logic               adv_out, adv_trk, adv_smp, take, move;
   logic [31:0]        prod;
   logic [13:0]        quot;
   logic [13:0]        ext;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms  <= MOVE_WINDOW_RST;
         cfg_ff.settle_ms  <= SETTLE_RST;
         cfg_ff.ext_len_mm <= EXT_LENGTH_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MOVE_WINDOW: cfg_ff.window_ms  <= csr_wdata;
            CSR_SETTLE:      cfg_ff.settle_ms  <= csr_wdata;
            CSR_EXT_LENGTH:  cfg_ff.ext_len_mm <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: a stage moves when empty or when the next one moves
   assign adv_out   = !out_vld_ff || !rsp_stall;
   assign adv_trk   = !trk_vld_ff || adv_out;
   assign adv_smp   = !smp_vld_ff || adv_trk;
   assign req_stall = !adv_smp;
   assign take      = smp_vld_ff && adv_trk;
   assign move      = trk_vld_ff && adv_out;

   // sample register
   always_comb begin
      smp_in.enc_a          = req_enc_a;
      smp_in.enc_b          = req_enc_b;
      smp_in.upper_released = req_upper_released;
      smp_in.lower_released = req_lower_released;
      smp_in.ms_tick        = req_ms_tick;
      smp_in.cmd_valid      = req_cmd_valid;
      smp_in.speed_present  = req_speed_present;
      smp_in.cmd_speed      = req_cmd_speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= 1'b0;
      end else if (adv_smp) begin
         smp_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_smp && req_valid) begin
         smp_ff <= smp_in;
      end
   end

   // tracker stage
   ahc_track u_track (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .smp   (smp_ff),
      .cfg   (cfg_ff),
      .trk   (trk)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_vld_ff <= 1'b0;
      end else if (adv_trk) begin
         trk_vld_ff <= smp_vld_ff;
      end
   end

   // length: extended length minus the difference over 17, toward zero
   assign prod = 32'(trk.diff_mag) * 32'(DIV_RECIP);
   assign quot = 14'(prod[DIV_SHIFT +: QUOT_W]);
   assign ext  = 14'(cfg_ff.ext_len_mm);

   always_comb begin
      len_in = len_ff;
      if (trk.homed) begin
         len_in = trk.diff_neg ? signed'(ext + quot) : signed'(ext - quot);
      end
   end

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff   <= 1'b0;
         out_ff.homed <= 1'b0;
         len_ff       <= '0;
      end else begin
         if (adv_out) begin
            out_vld_ff <= trk_vld_ff;
         end
         if (move) begin
            out_ff <= trk;
            len_ff <= len_in;
         end
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_position_count = out_ff.count;
   assign rsp_upper_state    = out_ff.upper_state;
   assign rsp_moving         = out_ff.moving;
   assign rsp_homed          = out_ff.homed;
   assign rsp_homed_count    = out_ff.homed_count;
   assign rsp_length_mm      = len_ff;
   assign rsp_drive_forward  = out_ff.fwd;
   assign rsp_drive_reverse  = out_ff.rev;

   // the two drive lines are never both on
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_drive_forward && rsp_drive_reverse))
      else $error("both drive lines active");

   // length stays zero until homing has latched
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_homed) |-> (rsp_length_mm == '0))
      else $error("length reported before homing");

   // homed never clears once set
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_homed)) |-> rsp_homed)
      else $error("homed flag cleared");

   // the sample channel stalls only with every stage occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (smp_vld_ff && trk_vld_ff && out_vld_ff && rsp_stall))
      else $error("sample channel stalled with room in the pipeline");

endmodule

[sim/actuator_homing_controller_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_homing_controller_top_tb
// Self-checking bench for the actuator homing controller.
// ----------------------------------------------------------------------------
// Sample words go in through the req_ channel and one status word per sample
// comes back on the rsp_ channel. A tracker object keeps its own copy of the
// encoder, speed, window and homing state. It predicts the status word for
// each accepted sample and checks the returned words in order. A short directed
// run comes first. Then several phases follow, each with its own window, settle
// and length setting. These phases mix homing attempts, encoder runs and random
// noise, with bursty sending and patterned result stalls.
// ----------------------------------------------------------------------------

// One returned status word, field by field
typedef struct packed {
   logic signed [15:0] position_count;
   logic               upper_state;
   logic               moving;
   logic               homed;
   logic signed [15:0] homed_count;
   logic signed [13:0] length_mm;
   logic               drive_forward;
   logic               drive_reverse;
} homing_status_type;

// Tracks the controller state and holds the status words still due
class homing_tracker;
   logic [3:0]         pin_hist;
   int                 step_acc;
   logic signed [15:0] count;
   logic signed [15:0] speed;
   logic [15:0]        win_elapsed;
   logic signed [15:0] count_at_win;
   bit                 moving;
   bit                 checking;
   logic [15:0]        settle_elapsed;
   bit                 homed;
   logic signed [15:0] homed_pos;
   logic signed [13:0] len_mm;
   logic [15:0]        window_ms;
   logic [15:0]        settle_ms;
   logic [9:0]         ext_len;
   int                 quad_step[16];
   homing_status_type  expected_status[$];
   int                 errors;

   function new();
      // step per {previous A,B, current A,B}
      quad_step      = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
      pin_hist       = 4'd3;
      step_acc       = 0;
      count          = '0;
      speed          = '0;
      win_elapsed    = '0;
      count_at_win   = '0;
      moving         = 1'b0;
      checking       = 1'b0;
      settle_elapsed = '0;
      homed          = 1'b0;
      homed_pos      = '0;
      len_mm         = '0;
      window_ms      = 16'd500;
      settle_ms      = 16'd5000;
      ext_len        = 10'd321;
      errors         = 0;
   endfunction

   function void set_config(logic [1:0] index, logic [15:0] data);
      case (index)
         ahc_pkg::CSR_MOVE_WINDOW: window_ms = data;
         ahc_pkg::CSR_SETTLE:      settle_ms = data;
         ahc_pkg::CSR_EXT_LENGTH:  ext_len   = data[9:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_status.size();
   endfunction

   // Advance the state by one accepted sample and queue its status word
   function void note_sample(ahc_pkg::ahc_sample_type s);
      homing_status_type st;
      int                diff;

      // quadrature decode, one detent per four steps
      pin_hist = {pin_hist[1:0], s.enc_a, s.enc_b};
      step_acc += quad_step[pin_hist];
      if (step_acc >= 4) begin
         count    = count + 16'sd1;
         step_acc = 0;
      end else if (step_acc <= -4) begin
         count    = count - 16'sd1;
         step_acc = 0;
      end

      // command capture, then limit switch gating
      if (s.cmd_valid && s.speed_present) speed = s.cmd_speed;
      if (speed > 0 && !s.upper_released) speed = '0;
      if (speed < 0 && !s.lower_released) speed = '0;

      // movement window
      if (s.ms_tick && win_elapsed != 16'hFFFF) win_elapsed = win_elapsed + 16'd1;
      if (win_elapsed >= window_ms) begin
         moving       = (count != count_at_win);
         count_at_win = count;
         win_elapsed  = '0;
      end

      // settle timer and stall check
      if (checking && s.ms_tick && settle_elapsed != 16'hFFFF)
         settle_elapsed = settle_elapsed + 16'd1;
      if (speed > 0 && !checking && s.cmd_valid) begin
         checking       = 1'b1;
         settle_elapsed = '0;
      end
      if (checking && settle_elapsed >= settle_ms) begin
         if (!moving && s.cmd_valid && speed == 1) begin
            homed     = 1'b1;
            homed_pos = count;
         end
         checking = 1'b0;
      end

      // length, divide truncates toward zero
      if (homed) begin
         diff   = int'(homed_pos) - int'(count);
         len_mm = 14'(int'(ext_len) - diff / 17);
      end

      st.position_count = count;
      st.upper_state    = s.upper_released;
      st.moving         = moving;
      st.homed          = homed;
      st.homed_count    = homed_pos;
      st.length_mm      = len_mm;
      st.drive_forward  = (speed > 0);
      st.drive_reverse  = (speed < 0);
      expected_status.push_back(st);
   endfunction

   function void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   // Check one returned status word against the oldest one due
   function void check_status(homing_status_type got);
      homing_status_type want;
      if (expected_status.size() == 0) begin
         $error("status word returned with none due");
         errors++;
         return;
      end
      want = expected_status.pop_front();
      compare_field("position_count", want.position_count, got.position_count);
      compare_field("upper_state", want.upper_state, got.upper_state);
      compare_field("moving", want.moving, got.moving);
      compare_field("homed", want.homed, got.homed);
      compare_field("homed_count", want.homed_count, got.homed_count);
      compare_field("length_mm", want.length_mm, got.length_mm);
      compare_field("drive_forward", want.drive_forward, got.drive_forward);
      compare_field("drive_reverse", want.drive_reverse, got.drive_reverse);
   endfunction

   function void flag_leftovers();
      if (expected_status.size() != 0) begin
         $error("%0d status words never returned", expected_status.size());
         errors++;
      end
   endfunction
endclass

module actuator_homing_controller_top_tb;
   import ahc_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int         DRAIN_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_enc_a = 1'b1;
   logic               req_enc_b = 1'b1;
   logic               req_upper_released = 1'b1;
   logic               req_lower_released = 1'b1;
   logic               req_ms_tick = 1'b0;
   logic               req_cmd_valid = 1'b0;
   logic               req_speed_present = 1'b0;
   logic signed [15:0] req_cmd_speed = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_position_count;
   logic               rsp_upper_state;
   logic               rsp_moving;
   logic               rsp_homed;
   logic signed [15:0] rsp_homed_count;
   logic signed [13:0] rsp_length_mm;
   logic               rsp_drive_forward;
   logic               rsp_drive_reverse;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   homing_tracker      tracker = new();
   ahc_sample_type     seen_sample;
   homing_status_type  seen_status;

   int                 burst_left = 0;
   int                 words_sent = 0;
   int                 enc_phase = 2;   // pins start at A=1, B=1
   int                 stall_mode = 0;
   int                 stall_span = 0;
   int unsigned        cycle_count = 0;

   actuator_homing_controller_top u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("actuator_homing_controller_top_tb: errors");
      $finish;
   end

   // Result side stall pattern; a new mode is picked each time its random span runs out
   always @(posedge clock) begin
      cycle_count++;
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(16, 200);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= cycle_count[2];
      endcase
   end

   // Watch both channels; predict on accepted samples, check accepted results
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         seen_sample.enc_a          = req_enc_a;
         seen_sample.enc_b          = req_enc_b;
         seen_sample.upper_released = req_upper_released;
         seen_sample.lower_released = req_lower_released;
         seen_sample.ms_tick        = req_ms_tick;
         seen_sample.cmd_valid      = req_cmd_valid;
         seen_sample.speed_present  = req_speed_present;
         seen_sample.cmd_speed      = req_cmd_speed;
         tracker.note_sample(seen_sample);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_status.position_count = rsp_position_count;
         seen_status.upper_state    = rsp_upper_state;
         seen_status.moving         = rsp_moving;
         seen_status.homed          = rsp_homed;
         seen_status.homed_count    = rsp_homed_count;
         seen_status.length_mm      = rsp_length_mm;
         seen_status.drive_forward  = rsp_drive_forward;
         seen_status.drive_reverse  = rsp_drive_reverse;
         tracker.check_status(seen_status);
      end
   end

   // Encoder pins for a gray code phase, forward is 00 -> 10 -> 11 -> 01
   function automatic logic [1:0] pins_at(input int phase);
      case (phase & 3)
         0: return 2'b00;
         1: return 2'b10;
         2: return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   function automatic logic signed [15:0] pick_speed();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'sd1;
         4: return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // Send one sample word; between bursts the sender may idle
   task automatic send_word(input logic enc_a, enc_b, upper, lower, tick, cmd, has_speed,
                            input logic signed [15:0] speed);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_enc_a          <= enc_a;
      req_enc_b          <= enc_b;
      req_upper_released <= upper;
      req_lower_released <= lower;
      req_ms_tick        <= tick;
      req_cmd_valid      <= cmd;
      req_speed_present  <= has_speed;
      req_cmd_speed      <= speed;
      req_valid          <= 1'b1;
      do @(posedge clock); while (req_stall);
      case ({enc_a, enc_b})
         2'b00: enc_phase = 0;
         2'b10: enc_phase = 1;
         2'b11: enc_phase = 2;
         default: enc_phase = 3;
      endcase
      words_sent++;
   endtask

   // Hold off the sender until every status word due has come back or the limit runs out
   task automatic drain(input int limit);
      int waited;
      req_valid <= 1'b0;
      @(posedge clock);
      for (waited = 0; waited < limit && tracker.pending() != 0; waited++)
         @(posedge clock);
   endtask

   task automatic put_csr(input logic [1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.set_config(index, data);
   endtask

   task automatic write_config(input logic [15:0] window, settle, ext_word,
                               input bit poke_unused);
      put_csr(CSR_MOVE_WINDOW, window);
      put_csr(CSR_SETTLE, settle);
      put_csr(CSR_EXT_LENGTH, ext_word);
      if (poke_unused) put_csr(CSR_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Commanded speed 1, at times 2, with the encoder mostly still, over a run sized from the settle time
   task automatic homing_attempt();
      int                 n;
      bit                 nudge;
      bit                 press;
      logic signed [15:0] target;
      logic [1:0]         ab;
      logic               sp;
      logic               cmd;
      n      = ((tracker.settle_ms > 40) ? 40 : int'(tracker.settle_ms)) + $urandom_range(2, 16);
      nudge  = ($urandom_range(0, 4) == 0);
      press  = ($urandom_range(0, 9) == 0);
      target = ($urandom_range(0, 5) == 0) ? 16'sd2 : 16'sd1;
      for (int i = 0; i < n; i++) begin
         sp  = (i == 0) || ($urandom_range(0, 1) == 0);
         cmd = (i == 0) || ($urandom_range(0, 7) != 0);
         ab  = pins_at(enc_phase + ((nudge && $urandom_range(0, 2) == 0) ? 1 : 0));
         send_word(ab[1], ab[0], !(press && $urandom_range(0, 3) == 0), 1'b1,
                   ($urandom_range(0, 3) != 0), cmd, sp, sp ? target : 16'($urandom));
      end
   endtask

   // Encoder travel in one direction with occasional reversals and commands
   task automatic motion_run();
      int         dir;
      int         n;
      logic [1:0] ab;
      dir = ($urandom_range(0, 1) == 0) ? 1 : -1;
      n   = 4 * $urandom_range(1, 8) + $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) dir = -dir;
         ab = pins_at(enc_phase + (($urandom_range(0, 7) == 0) ? 0 : dir));
         send_word(ab[1], ab[0], ($urandom_range(0, 9) != 0), ($urandom_range(0, 9) != 0),
                   1'($urandom), ($urandom_range(0, 7) == 0), 1'($urandom), pick_speed());
      end
   endtask

   task automatic noise_words(input int n);
      for (int i = 0; i < n; i++)
         send_word(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom), 16'($urandom));
   endtask

   task automatic run_phase(input logic [15:0] window, settle, ext_word,
                            input bit poke_unused, input int words);
      int target;
      int pick;
      drain(DRAIN_LIMIT);
      write_config(window, settle, ext_word, poke_unused);
      target = words_sent + words;
      while (words_sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) homing_attempt();
         else if (pick < 8) motion_run();
         else noise_words($urandom_range(1, 8));
      end
   endtask

   initial begin
      logic [1:0] ab;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: drive lines, limit gating, command forms, encoder steps
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'sd0);
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'sh7FFF);
      send_word(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'sd0);
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'sh8000);
      send_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'sd0);
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'sd100);
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'sd5);
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, -16'sd1);
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, -16'sd7);
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, -16'sd1);
      send_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd0);
      for (int i = 0; i < 4; i++) begin
         ab = pins_at(enc_phase + 1);
         send_word(ab[1], ab[0], 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'sd0);
      end
      for (int i = 0; i < 8; i++) begin
         ab = pins_at(enc_phase - 1);
         send_word(ab[1], ab[0], 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'sd0);
      end
      // both pins flip at once: an invalid transition, no step
      ab = pins_at(enc_phase + 2);
      send_word(ab[1], ab[0], 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'sd0);

      // random phases over low, zero, typical and extreme settings
      run_phase(16'd1, 16'd1, {6'($urandom), 10'd0}, 1'b0, 165);
      run_phase(16'd2, 16'd6, {6'($urandom), 10'd1023}, 1'b1, 165);
      run_phase(16'd0, 16'd0, {6'($urandom), 10'd512}, 1'b0, 165);
      run_phase(16'd5, 16'd20, 16'd321, 1'b0, 165);
      run_phase(16'd65535, 16'd65535, 16'hFFFF, 1'b0, 60);
      run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 30)), 16'($urandom),
                1'b1, 165);
      run_phase(16'd3, 16'd3, 16'($urandom), 1'b0, 165);

      // wait out the pipeline, then report
      drain(DRAIN_LIMIT);
      repeat (6) @(posedge clock);
      tracker.flag_leftovers();
      if (tracker.errors == 0)
         $display("actuator_homing_controller_top_tb: clean");
      else
         $display("actuator_homing_controller_top_tb: errors");
      $finish;
   end

endmodule

[actuator_homing_controller_top.f]
rtl/core/ahc_pkg.sv
rtl/core/ahc_track.sv
rtl/core/actuator_homing_controller_top.sv
sim/actuator_homing_controller_top_tb.sv
